// File: rtl/table_driven_state_machine_unit_assert.svh
// Assertion macros for the table driven state machine unit.
`ifndef TABLE_DRIVEN_STATE_MACHINE_UNIT_ASSERT_SVH
`define TABLE_DRIVEN_STATE_MACHINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TDSM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tdsm assertion failed");

// Next-cycle implication, checked outside reset.
`define TDSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tdsm assertion failed");

`endif

// File: rtl/tdsm_pkg.sv
// Package: types, widths and register indexes of the table driven state machine.
`default_nettype none
package tdsm_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int STATE_W         = 8;
  localparam int SLOT_W          = 8;
  localparam int N_IN            = 4;
  localparam int N_OUT           = 4;
  localparam int IDX_W           = 4;
  localparam int CARE_W          = N_IN;
  localparam int IN_VEC_W        = N_IN * SLOT_W;
  localparam int OUT_VEC_W       = N_OUT * SLOT_W;
  localparam int TIU_W           = 5;
  localparam int CNT3_W          = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;

  localparam logic [STATE_W-1:0] START_STATE_RST = '0;
  localparam logic [TIU_W-1:0]   TIU_RST         = '0;
  localparam logic [CNT3_W-1:0]  IIU_RST         = 3'd4;
  localparam logic [CNT3_W-1:0]  OIU_RST         = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_STATE = 2'd0,
    CFG_TRANS_USE   = 2'd1,
    CFG_INPUTS_USE  = 2'd2,
    CFG_OUTPUTS_USE = 2'd3
  } cfg_reg_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef struct packed {
    logic                 src_any;
    logic [STATE_W-1:0]   src;
    logic [STATE_W-1:0]   target;
    logic [IN_VEC_W-1:0]  expected;
    logic [CARE_W-1:0]    care;
    logic [OUT_VEC_W-1:0] emits;
  } entry_t;

  typedef struct packed {
    logic                 start_load;
    logic [STATE_W-1:0]   start_val;
    logic [TIU_W-1:0]     tiu;
    logic [CNT3_W-1:0]    iiu;
    logic [CNT3_W-1:0]    oiu;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/tdsm_table_ram.sv
// Transition table memory: one write port, one read port with registered data.
`default_nettype none
module tdsm_table_ram
  import tdsm_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/tdsm_ctrl.sv
// Search sequencer: walks the table one entry a cycle and emits the result item.
`default_nettype none
module tdsm_ctrl
  import tdsm_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  input  wire logic                 start,
  input  wire logic                 kind,
  input  wire logic [IN_VEC_W-1:0]  event_inputs,
  output logic                      busy,
  output logic [AW-1:0]             raddr,
  input  wire entry_t               rdata,
  output logic                      out_valid,
  output logic                      out_matched,
  output logic [IDX_W-1:0]          out_fired_index,
  output logic [STATE_W-1:0]        out_state_now,
  output logic [OUT_VEC_W-1:0]      out_output_values
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + AW + 1;

  typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

  state_t                state_r;
  logic [STATE_W-1:0]    cur_state_r;
  logic [IN_VEC_W-1:0]   ev_r;
  logic [N_IN-1:0]       in_mask_r;
  logic [N_OUT-1:0]      out_mask_r;
  logic [CW-1:0]         ntr_r;
  logic [AW-1:0]         chk_r;
  logic                  out_valid_r;
  logic                  out_matched_r;
  logic [IDX_W-1:0]      out_fired_index_r;
  logic [STATE_W-1:0]    out_state_now_r;
  logic [OUT_VEC_W-1:0]  out_output_values_r;

  logic [CW-1:0]         ntr_nxt;
  logic [N_IN-1:0]       in_mask_nxt;
  logic [N_OUT-1:0]      out_mask_nxt;
  logic [N_IN-1:0]       mismatch;
  logic [OUT_VEC_W-1:0]  emits_masked;
  logic                  src_ok;
  logic                  hit;
  logic                  last;

  always_comb begin
    ntr_nxt = (32'(cfg.tiu) > DEPTH) ? CW'(DEPTH) : CW'(cfg.tiu);
    for (int i = 0; i < N_IN; i++) begin
      in_mask_nxt[i] = (32'(cfg.iiu) > i);
    end
    for (int i = 0; i < N_OUT; i++) begin
      out_mask_nxt[i] = (32'(cfg.oiu) > i);
    end
  end

  always_comb begin
    src_ok = rdata.src_any || (rdata.src == cur_state_r);
    for (int i = 0; i < N_IN; i++) begin
      mismatch[i] = in_mask_r[i] && rdata.care[i] &&
                    (ev_r[i*SLOT_W +: SLOT_W] != rdata.expected[i*SLOT_W +: SLOT_W]);
    end
    for (int i = 0; i < N_OUT; i++) begin
      emits_masked[i*SLOT_W +: SLOT_W] = out_mask_r[i] ? rdata.emits[i*SLOT_W +: SLOT_W]
                                                       : '0;
    end
    hit  = src_ok && !(|mismatch);
    last = (XW'(chk_r) + XW'(1)) == XW'(ntr_r);
  end

  assign busy  = (state_r == ST_SEARCH);
  assign raddr = (state_r == ST_SEARCH) ? (chk_r + AW'(1)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_state_r <= START_STATE_RST;
      chk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg.start_load) begin
        cur_state_r <= cfg.start_val;
      end
      case (state_r)
        ST_IDLE: begin
          if (start && (kind == KIND_EVENT)) begin
            ev_r       <= event_inputs;
            in_mask_r  <= in_mask_nxt;
            out_mask_r <= out_mask_nxt;
            ntr_r      <= ntr_nxt;
            chk_r      <= '0;
            if (ntr_nxt == '0) begin
              out_valid_r         <= 1'b1;
              out_matched_r       <= 1'b0;
              out_fired_index_r   <= '0;
              out_state_now_r     <= cur_state_r;
              out_output_values_r <= '0;
            end else begin
              state_r <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            state_r             <= ST_IDLE;
            cur_state_r         <= rdata.target;
            out_valid_r         <= 1'b1;
            out_matched_r       <= 1'b1;
            out_fired_index_r   <= IDX_W'(chk_r);
            out_state_now_r     <= rdata.target;
            out_output_values_r <= emits_masked;
          end else if (last) begin
            state_r             <= ST_IDLE;
            out_valid_r         <= 1'b1;
            out_matched_r       <= 1'b0;
            out_fired_index_r   <= '0;
            out_state_now_r     <= cur_state_r;
            out_output_values_r <= '0;
          end else begin
            chk_r <= chk_r + AW'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_matched       = out_matched_r;
  assign out_fired_index   = out_fired_index_r;
  assign out_state_now     = out_state_now_r;
  assign out_output_values = out_output_values_r;

endmodule
`default_nettype wire

// File: rtl/table_driven_state_machine_unit.sv
// A load item with an index inside the table is written at the edge that takes it and gives
// no result. An event item searches the entries, one a cycle through the table memory's read
// port, up to and including the first match, else transitions_in_use (capped at table depth)
// of them; with transitions_in_use zero the result comes at the edge that takes it. One load a
// cycle while busy is low; a new event is taken after the last result, busy high meanwhile.
// Synchronous reset (rst_n low) sets control state and config registers; table is not cleared.
`default_nettype none
module table_driven_state_machine_unit
  import tdsm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_kind,
  input  wire logic [IDX_W-1:0]      in_entry_index,
  input  wire logic [STATE_W-1:0]    in_entry_source,
  input  wire logic                  in_entry_source_any,
  input  wire logic [STATE_W-1:0]    in_entry_target,
  input  wire logic [IN_VEC_W-1:0]   in_entry_expected,
  input  wire logic [CARE_W-1:0]     in_entry_care,
  input  wire logic [OUT_VEC_W-1:0]  in_entry_emits,
  input  wire logic [IN_VEC_W-1:0]   in_event_inputs,
  output logic                       out_valid,
  output logic                       out_matched,
  output logic [IDX_W-1:0]           out_fired_index,
  output logic [STATE_W-1:0]         out_state_now,
  output logic [OUT_VEC_W-1:0]       out_output_values,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [TIU_W-1:0]  tiu_r;
  logic [CNT3_W-1:0] iiu_r;
  logic [CNT3_W-1:0] oiu_r;
  cfg_t              cfg;
  entry_t            wr_ent;
  entry_t            rd_ent;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiu_r <= TIU_RST;
      iiu_r <= IIU_RST;
      oiu_r <= OIU_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRANS_USE:   tiu_r <= cfg_data[TIU_W-1:0];
        CFG_INPUTS_USE:  iiu_r <= cfg_data[CNT3_W-1:0];
        CFG_OUTPUTS_USE: oiu_r <= cfg_data[CNT3_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.start_load = cfg_we && (cfg_index == CFG_START_STATE);
    cfg.start_val  = cfg_data[STATE_W-1:0];
    cfg.tiu        = tiu_r;
    cfg.iiu        = iiu_r;
    cfg.oiu        = oiu_r;

    wr_ent.src_any  = in_entry_source_any;
    wr_ent.src      = in_entry_source;
    wr_ent.target   = in_entry_target;
    wr_ent.expected = in_entry_expected;
    wr_ent.care     = in_entry_care;
    wr_ent.emits    = in_entry_emits;
  end

  assign ram_we    = start && !busy && (in_kind == KIND_LOAD) &&
                     (32'(in_entry_index) < TABLE_DEPTH);
  assign ram_waddr = AW'(in_entry_index);

  tdsm_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (ram_raddr),
    .rdata (rd_ent)
  );

  tdsm_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .start             (start),
    .kind              (in_kind),
    .event_inputs      (in_event_inputs),
    .busy              (busy),
    .raddr             (ram_raddr),
    .rdata             (rd_ent),
    .out_valid         (out_valid),
    .out_matched       (out_matched),
    .out_fired_index   (out_fired_index),
    .out_state_now     (out_state_now),
    .out_output_values (out_output_values)
  );

endmodule
`default_nettype wire

// File: rtl/tdsm_checker.sv
// Port-level checker for the table driven state machine unit, with its bind.
`default_nettype none
`include "table_driven_state_machine_unit_assert.svh"
module tdsm_checker
  import tdsm_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 in_kind,
  input wire logic                 out_valid,
  input wire logic                 out_matched,
  input wire logic [IDX_W-1:0]     out_fired_index,
  input wire logic [OUT_VEC_W-1:0] out_output_values
);

  logic load_acc;
  logic event_acc;
  logic nomatch;
  logic nomatch_clean;

  assign load_acc      = start && !busy && (in_kind == KIND_LOAD);
  assign event_acc     = start && !busy && (in_kind == KIND_EVENT);
  assign nomatch       = out_valid && !out_matched;
  assign nomatch_clean = (out_fired_index == '0) && (out_output_values == '0);

  `TDSM_ASSERT_NEXT(a_load_no_result, clk, rst_n, load_acc, !out_valid)
  `TDSM_ASSERT_NEXT(a_event_progress, clk, rst_n, event_acc, busy || out_valid)
  `TDSM_ASSERT_SAME(a_result_when_idle, clk, rst_n, out_valid, !busy)
  `TDSM_ASSERT_SAME(a_nomatch_zero, clk, rst_n, nomatch, nomatch_clean)

endmodule

bind table_driven_state_machine_unit tdsm_checker u_tdsm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_kind           (in_kind),
  .out_valid         (out_valid),
  .out_matched       (out_matched),
  .out_fired_index   (out_fired_index),
  .out_output_values (out_output_values)
);
`default_nettype wire
